// ----- hw/rtl/gbs_pkg.sv -----
// Package: shared types, constants and state encoding for the group-by sum engine.
`default_nettype none
package gbs_pkg;
  localparam int unsigned KEY_W = 31;
  localparam int unsigned VAL_W = 31;
  localparam int unsigned SUM_W = 48;
  localparam int unsigned ID_W = 10;
  localparam int unsigned MAX_GROUPS_DEF = 1024;

  typedef struct packed {
    logic [KEY_W-1:0] group_key;
    logic [VAL_W-1:0] row_value;
    logic             last_of_batch;
  } gbs_in_t;

  typedef struct packed {
    logic [ID_W-1:0]  grp_idx;
    logic             is_new_group;
    logic [SUM_W-1:0] running_sum;
    logic             sum_saturated;
    logic             table_full;
    logic             batch_done;
  } gbs_out_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_UPD, ST_NEW, ST_FULL
  } gbs_state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic load;      // capture request, clear scan index
    logic scan_rd;   // issue key read at scan index, advance
    logic upd;       // add into the found slot, emit result
    logic ins;       // append new group, emit result
    logic drop;      // emit table-full result
  } gbs_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic hit;       // registered key read matched
    logic rd_pend;   // a key read is in flight
    logic scan_end;  // no more slots to issue
    logic full;      // all slots in use
  } gbs_sts_t;
endpackage
`default_nettype wire

// ----- hw/rtl/gbs_ctrl.sv -----
// Controller state machine sequencing lookup, update, insert and drop.
`default_nettype none
module gbs_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire gbs_pkg::gbs_sts_t sts,
  output gbs_pkg::gbs_cmd_t      cmd,
  output logic                   busy
);
  import gbs_pkg::*;
  gbs_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (start) state_nxt = ST_SCAN;
      ST_SCAN: begin
        if (sts.rd_pend && sts.hit) state_nxt = ST_UPD;
        else if (!sts.rd_pend && sts.scan_end) state_nxt = sts.full ? ST_FULL : ST_NEW;
      end
      ST_UPD, ST_NEW, ST_FULL: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        cmd.load = start;
      end
      ST_SCAN: cmd.scan_rd = !sts.scan_end && !(sts.rd_pend && sts.hit);
      ST_UPD:  cmd.upd = 1'b1;
      ST_NEW:  cmd.ins = 1'b1;
      ST_FULL: cmd.drop = 1'b1;
      default: busy = 1'b1;
    endcase
  end
endmodule
`default_nettype wire

// ----- hw/rtl/gbs_dp.sv -----
// Datapath: key and sum memories, scan index, group count and result register.
`default_nettype none
module gbs_dp #(
  parameter int unsigned MAX_GROUPS = gbs_pkg::MAX_GROUPS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire gbs_pkg::gbs_in_t  in_req,
  input  wire gbs_pkg::gbs_cmd_t cmd,
  output gbs_pkg::gbs_sts_t      sts,
  output gbs_pkg::gbs_out_t      out_res,
  output logic                   out_valid
);
  import gbs_pkg::*;
  localparam int unsigned AW = $clog2(MAX_GROUPS);
  localparam int unsigned CW = AW + 1;
  localparam logic [CW-1:0] MAXC = CW'(MAX_GROUPS);
  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  logic [KEY_W-1:0] key_mem [MAX_GROUPS];
  logic [SUM_W-1:0] sum_mem [MAX_GROUPS];

  gbs_in_t          req_r;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [CW-1:0]    idx_r;
  logic [AW-1:0]    slot_r;     // address of the key in flight
  logic             pend_r;
  logic [KEY_W-1:0] key_rd_r;
  logic [SUM_W-1:0] sum_rd_r;
  logic             valid_r;
  gbs_out_t         res_r;
  logic [SUM_W:0]   add_w;
  logic             hit_w;

  assign hit_w = (key_rd_r == req_r.group_key);
  assign sts.hit = hit_w;
  assign sts.rd_pend = pend_r;
  assign sts.scan_end = (idx_r == cnt_r);
  assign sts.full = (cnt_r == MAXC);
  assign add_w = {1'b0, sum_rd_r} + {{(SUM_W-VAL_W+1){1'b0}}, req_r.row_value};

  // Memory reads: key and sum at the issued scan slot.
  always_ff @(posedge clk) begin
    if (cmd.scan_rd) begin
      key_rd_r <= key_mem[idx_r[AW-1:0]];
      sum_rd_r <= sum_mem[idx_r[AW-1:0]];
      slot_r   <= idx_r[AW-1:0];
    end
  end

  // Memory writes.
  always_ff @(posedge clk) begin
    if (cmd.ins) begin
      key_mem[cnt_r[AW-1:0]] <= req_r.group_key;
      sum_mem[cnt_r[AW-1:0]] <= {{(SUM_W-VAL_W){1'b0}}, req_r.row_value};
    end else if (cmd.upd) begin
      sum_mem[slot_r] <= add_w[SUM_W] ? SUM_MAX : add_w[SUM_W-1:0];
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.ins) cnt_nxt = cnt_r + CW'(1);
    if ((cmd.ins || cmd.upd || cmd.drop) && req_r.last_of_batch) cnt_nxt = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      idx_r   <= '0;
      pend_r  <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      cnt_r   <= cnt_nxt;
      valid_r <= cmd.ins || cmd.upd || cmd.drop;
      if (cmd.load) begin
        idx_r  <= '0;
        pend_r <= 1'b0;
      end else begin
        pend_r <= cmd.scan_rd;
        if (cmd.scan_rd) idx_r <= idx_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) req_r <= in_req;
    if (cmd.ins || cmd.upd || cmd.drop) begin
      res_r.is_new_group  <= cmd.ins;
      res_r.sum_saturated <= cmd.upd && add_w[SUM_W];
      res_r.table_full    <= cmd.drop;
      res_r.batch_done    <= req_r.last_of_batch;
      if (cmd.ins) begin
        res_r.grp_idx     <= ID_W'(cnt_r[AW-1:0]);
        res_r.running_sum <= {{(SUM_W-VAL_W){1'b0}}, req_r.row_value};
      end else if (cmd.upd) begin
        res_r.grp_idx     <= ID_W'(slot_r);
        res_r.running_sum <= add_w[SUM_W] ? SUM_MAX : add_w[SUM_W-1:0];
      end else begin
        res_r.grp_idx     <= '0;
        res_r.running_sum <= '0;
      end
    end
  end

  assign out_res = res_r;
  assign out_valid = valid_r;
endmodule
`default_nettype wire

// ----- hw/rtl/group_by_sum_aggregation.sv -----
// Top level of the group-by sum engine: controller plus datapath.
`default_nettype none
// A request is taken at a rising edge where start is high and busy is low. The
// engine then compares the key against the slots in use, one slot per cycle
// through the registered key memory, and this linear scan sets the time per
// request. A key that is found updates its slot; a new key is appended, or
// dropped when the table is full, once every slot in use has been compared.
// Busy falls in the cycle that shows the result, so the next request can be
// taken at the edge that ends it. Each request yields exactly one result,
// shown for one cycle with out_valid; the receiver cannot stall it. A request
// with last_of_batch set empties the table once its result is produced. No
// clearing pass is needed after reset, since only slots below the group count
// are ever read.
module group_by_sum_aggregation #(
  parameter int unsigned MAX_GROUPS = gbs_pkg::MAX_GROUPS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire gbs_pkg::gbs_in_t  in_req,
  output logic                   out_valid,
  output gbs_pkg::gbs_out_t      out_res
);
  import gbs_pkg::*;
  gbs_cmd_t cmd;
  gbs_sts_t sts;

  // Sequencing of each request.
  gbs_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .sts(sts), .cmd(cmd), .busy(busy)
  );

  // Table storage, sum arithmetic and the result register.
  gbs_dp #(.MAX_GROUPS(MAX_GROUPS)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_req(in_req), .cmd(cmd), .sts(sts),
    .out_res(out_res), .out_valid(out_valid)
  );
endmodule
`default_nettype wire

// ----- hw/rtl/gbs_chk.sv -----
// Port-level checker for the group-by sum engine and its bind.
`default_nettype none
module gbs_chk (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              start,
  input wire logic              busy,
  input wire logic              out_valid,
  input wire gbs_pkg::gbs_out_t out_res
);
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("busy not raised after request");
  a_one_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot0({out_res.is_new_group, out_res.table_full,
                            out_res.sum_saturated})) else $error("flags clash");
  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res.table_full |-> out_res.running_sum == '0)
    else $error("dropped request with nonzero sum");
  a_valid_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result longer than one cycle");
endmodule

bind group_by_sum_aggregation gbs_chk u_gbs_chk (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .out_res(out_res)
);
`default_nettype wire

// ----- tb/sv/group_by_sum_aggregation_tb.sv -----
// Self-checking testbench for the group-by sum engine with a built-in table predictor.
`timescale 1ns / 100ps
`default_nettype none
module group_by_sum_aggregation_tb;
  import gbs_pkg::*;

  localparam int unsigned NGROUPS = MAX_GROUPS_DEF;
  localparam logic [SUM_W-1:0] SUM_CEIL = {SUM_W{1'b1}};
  localparam longint unsigned CYCLE_LIMIT = 64'd12_000_000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  gbs_in_t in_req = '0;
  logic out_valid;
  gbs_out_t out_res;

  group_by_sum_aggregation DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req(in_req), .out_valid(out_valid), .out_res(out_res)
  );

  always #5 clk = ~clk;

  // Predictor state: a mirror of the group table.
  logic [KEY_W-1:0] mirror_keys[NGROUPS];
  logic [SUM_W-1:0] mirror_sums[NGROUPS];
  int unsigned mirror_count = 0;

  // Expected results, oldest first.
  gbs_out_t pending_results[$];

  int unsigned mismatch_count = 0;
  int unsigned results_seen = 0;
  int unsigned requests_sent = 0;
  int unsigned new_seen = 0;
  int unsigned gap_pct = 0;
  longint unsigned cycle_count = 0;

  // Computes the result for one request and updates the mirror table.
  function automatic gbs_out_t aggregate_row(gbs_in_t req);
    gbs_out_t res;
    int slot;
    logic [SUM_W:0] wide;
    res = '0;
    slot = -1;
    for (int i = 0; i < int'(mirror_count); i++) begin
      if (slot < 0 && mirror_keys[i] == req.group_key) slot = i;
    end
    if (slot >= 0) begin
      wide = {1'b0, mirror_sums[slot]} + (SUM_W+1)'(req.row_value);
      if (wide > {1'b0, SUM_CEIL}) begin
        wide = {1'b0, SUM_CEIL};
        res.sum_saturated = 1'b1;
      end
      mirror_sums[slot] = wide[SUM_W-1:0];
      res.grp_idx = ID_W'(slot);
      res.running_sum = wide[SUM_W-1:0];
    end else if (mirror_count < NGROUPS) begin
      mirror_keys[mirror_count] = req.group_key;
      mirror_sums[mirror_count] = SUM_W'(req.row_value);
      res.grp_idx = ID_W'(mirror_count);
      res.is_new_group = 1'b1;
      res.running_sum = SUM_W'(req.row_value);
      mirror_count++;
    end else begin
      res.table_full = 1'b1;
    end
    res.batch_done = req.last_of_batch;
    if (req.last_of_batch) mirror_count = 0;
    return res;
  endfunction

  // Cycle counter and watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Result checker: every strobed result is compared with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      results_seen++;
      if (out_res.is_new_group) new_seen++;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("Unexpected result %p", out_res);
      end else begin
        gbs_out_t want;
        want = pending_results.pop_front();
        if (out_res !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("Result mismatch: expected %p, got %p", want, out_res);
        end
      end
    end
  end

  // Sends one request: at least one edge with start low, the optional idle gap,
  // then start held until accepted. The expectation is recorded at the
  // accepting edge, before the result can appear.
  task automatic send_row(input logic [KEY_W-1:0] key, input logic [VAL_W-1:0] val,
                          input logic last);
    gbs_in_t req;
    req.group_key = key;
    req.row_value = val;
    req.last_of_batch = last;
    @(posedge clk);
    while ($urandom_range(99) < gap_pct) @(posedge clk);
    start <= 1'b1;
    in_req <= req;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(aggregate_row(req));
    requests_sent++;
    start <= 1'b0;
  endtask

  // Holds off new requests until every expected result has come.
  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Field extremes, known keys and end of batch.
  task automatic test_directed();
    send_row('0, '0, 1'b0);
    send_row({KEY_W{1'b1}}, {VAL_W{1'b1}}, 1'b0);
    send_row('0, {VAL_W{1'b1}}, 1'b0);
    send_row({KEY_W{1'b1}}, '0, 1'b0);
    send_row(31'h2AAA_AAAA, 31'h5555_5555, 1'b0);
    send_row(31'h5555_5555, 31'h2AAA_AAAA, 1'b0);
    send_row(31'h2AAA_AAAA, 31'h1, 1'b1);
    // After the batch ends the same key is new again with id zero.
    send_row(31'h2AAA_AAAA, 31'h7, 1'b0);
    send_row(31'h2AAA_AAAA, 31'h7, 1'b1);
  endtask

  // Batches of random rows drawn mostly from a small key pool so keys repeat.
  task automatic test_random(input int unsigned rows, input int unsigned pct);
    logic [KEY_W-1:0] pool[16];
    gap_pct = pct;
    for (int i = 0; i < 16; i++) pool[i] = KEY_W'($urandom);
    for (int unsigned n = 0; n < rows; n++) begin
      logic [KEY_W-1:0] key;
      logic [VAL_W-1:0] val;
      if ($urandom_range(9) < 8) key = pool[$urandom_range(15)];
      else key = KEY_W'($urandom);
      case ($urandom_range(3))
        0: val = {VAL_W{1'b1}};
        1: val = VAL_W'($urandom_range(255));
        default: val = VAL_W'($urandom);
      endcase
      send_row(key, val, $urandom_range(19) == 0);
    end
  endtask

  initial begin
    start <= 1'b0;
    in_req <= '0;
    rst_n <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    gap_pct = 14;
    test_directed();
    test_random(220, 14);
    // Pause the sender until the engine has fully drained.
    wait_drained();
    test_random(220, 58);
    test_random(200, 0);
    gap_pct = 0;
    send_row('0, '0, 1'b1);
    wait_drained();
    repeat (20) @(posedge clk);
    $display("Covered %0d requests and %0d results, %0d of them opening a new group,",
             requests_sent, results_seen, new_seen);
    $display("with directed extremes and random batches under three idle profiles.");
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ----- group_by_sum_aggregation.f -----
hw/rtl/gbs_pkg.sv
hw/rtl/gbs_ctrl.sv
hw/rtl/gbs_dp.sv
hw/rtl/group_by_sum_aggregation.sv
hw/rtl/gbs_chk.sv
tb/sv/group_by_sum_aggregation_tb.sv
